// File: design/tts_pkg.sv
// Shared types and constants for the timer table scheduler.
// Used by tts_front, tts_back and timer_table_scheduler; depends on nothing.

package tts_pkg;

    // Stream payload widths, fixed by the field layout.
    localparam int IN_TDATA_W  = 144;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Command codes as they arrive on the input stream.
    typedef enum logic [2:0] {
        CMD_CREATE  = 3'd0,
        CMD_CANCEL  = 3'd1,
        CMD_PAUSE   = 3'd2,
        CMD_RESUME  = 3'd3,
        CMD_PROCESS = 3'd4,
        CMD_QUERY   = 3'd5
    } cmd_code_t;

    // Operations after classification by the front.
    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_CANCEL  = 3'd1,
        OP_PAUSE   = 3'd2,
        OP_RESUME  = 3'd3,
        OP_PROCESS = 3'd4,
        OP_QUERY   = 3'd5,
        OP_REJECT  = 3'd6
    } op_t;

    // Result kinds on the output stream.
    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_FIRE  = 2'd1,
        KIND_DONE  = 2'd2
    } res_kind_t;

    // One classified command in the queue (the time word travels beside it).
    typedef struct packed {
        op_t         op;
        logic        slot_ok;
        logic [3:0]  slot;
        logic [15:0] dest;
        logic [7:0]  msg_kind;
        logic [31:0] interval;
        logic        repeat_req;
    } cmd_t;

    // One result item.
    typedef struct packed {
        res_kind_t   kind;
        logic        ok;
        logic [3:0]  slot_index;
        logic [15:0] fire_dest;
        logic [7:0]  fire_kind;
        logic [4:0]  fired_count;
        logic        is_active;
        logic        last;
    } result_t;

endpackage

// File: design/timer_table_scheduler.sv
// Timer table scheduler: a command front with a two-entry queue feeds the slot table back end.
// A simple command is registered in the queue and then in the result register; simple commands
// are taken one per cycle while the output is not stalled. Create searches one slot per cycle.
// Process reads one slot per cycle through the table memory while the output is not stalled.
// Reset clears the used and active flags, the queue and the result register at once.
// Depends on tts_pkg, tts_front and tts_back.

module timer_table_scheduler #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: slot, dest_id, msg_kind, interval_ms, start_delay, repeat_req, now_ms.
    input  logic [tts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: cmd.
    input  logic [tts_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: ok, slot_index, fire_dest, fire_kind, fired_count, is_active.
    output logic [tts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // Fields from bit 0: kind.
    output logic [tts_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tlast
);

    logic                   q_valid;
    tts_pkg::cmd_t          q_cmd;
    logic [TIME_BITS-1:0]   q_time;
    logic                   q_pop;
    tts_pkg::result_t       res;

    // Command front and queue.
    tts_front #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_time        (q_time),
        .q_pop         (q_pop)
    );

    // Slot table and scan sequencer.
    tts_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_time    (q_time),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result onto the output stream.
    assign m_axis_tdata = {5'b00000, res.is_active, res.fired_count, res.fire_kind,
                           res.fire_dest, res.slot_index, res.ok};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

`ifndef SYNTH
    // Only fire results leave the run open; replies and scan ends close it.
    a_last_by_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (res.kind != tts_pkg::KIND_FIRE)))
        else $error("tlast does not match result kind");

    // A scan cannot report more firings than there are slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.kind == tts_pkg::KIND_DONE) |-> (res.fired_count <= 5'(SLOTS)))
        else $error("fired count exceeds slot count");

    // Fire and done results always report success and carry no query answer.
    a_scan_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.kind != tts_pkg::KIND_REPLY) |-> (res.ok && !res.is_active))
        else $error("scan result with bad status");

    // An accepted command is held in the queue in the following cycle.
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> q_valid)
        else $error("accepted command missing from queue");
`endif

endmodule

// File: design/tts_front.sv
// Front part of the timer table scheduler: accepts commands, classifies them,
// computes the create expiry and queues them. Depends on tts_pkg.

module tts_front #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [tts_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             q_valid,
    output tts_pkg::cmd_t                    q_cmd,
    output logic [TIME_BITS-1:0]             q_time,
    input  logic                             q_pop
);

    localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam int PTR_W = (tts_pkg::QUEUE_DEPTH > 1) ? $clog2(tts_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tts_pkg::QUEUE_DEPTH + 1);

    logic [3:0]              f_slot;
    logic [15:0]             f_dest;
    logic [7:0]              f_kind;
    logic [31:0]             f_interval;
    logic [31:0]             f_delay;
    logic                    f_repeat;
    logic [47:0]             f_now;
    logic [TIME_BITS+47:0]   now_ext;
    logic [TIME_BITS-1:0]    now_t;
    logic [SUM_W-1:0]        create_sum;
    logic [TIME_BITS-1:0]    create_time;
    tts_pkg::cmd_t           in_cmd;
    logic [TIME_BITS-1:0]    in_time;
    logic                    push;

    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    tts_pkg::cmd_t           cmd_mem [tts_pkg::QUEUE_DEPTH];
    logic [TIME_BITS-1:0]    time_mem [tts_pkg::QUEUE_DEPTH];

    // Unpack the input fields.
    assign f_slot     = s_axis_tdata[3:0];
    assign f_dest     = s_axis_tdata[19:4];
    assign f_kind     = s_axis_tdata[27:20];
    assign f_interval = s_axis_tdata[59:28];
    assign f_delay    = s_axis_tdata[91:60];
    assign f_repeat   = s_axis_tdata[92];
    assign f_now      = s_axis_tdata[140:93];

    // Time is kept modulo the time width.
    assign now_ext = {{TIME_BITS{1'b0}}, f_now};
    assign now_t   = now_ext[TIME_BITS-1:0];

    // First expiry of a create, saturated at the largest time value.
    assign create_sum  = SUM_W'(now_t) + SUM_W'(f_delay);
    assign create_time = (|(create_sum >> TIME_BITS)) ? {TIME_BITS{1'b1}}
                                                       : create_sum[TIME_BITS-1:0];

    // Classify the command.
    always_comb
    begin
        in_cmd.slot_ok    = {2'b00, f_slot} < 6'(SLOTS);
        in_cmd.slot       = f_slot;
        in_cmd.dest       = f_dest;
        in_cmd.msg_kind   = f_kind;
        in_cmd.interval   = f_interval;
        in_cmd.repeat_req = f_repeat;
        unique case (s_axis_tuser)
            tts_pkg::CMD_CREATE:  in_cmd.op = (f_interval != 32'd0) ? tts_pkg::OP_CREATE
                                                                    : tts_pkg::OP_REJECT;
            tts_pkg::CMD_CANCEL:  in_cmd.op = tts_pkg::OP_CANCEL;
            tts_pkg::CMD_PAUSE:   in_cmd.op = tts_pkg::OP_PAUSE;
            tts_pkg::CMD_RESUME:  in_cmd.op = tts_pkg::OP_RESUME;
            tts_pkg::CMD_PROCESS: in_cmd.op = tts_pkg::OP_PROCESS;
            tts_pkg::CMD_QUERY:   in_cmd.op = tts_pkg::OP_QUERY;
            default:              in_cmd.op = tts_pkg::OP_REJECT;
        endcase
    end

    // A create carries its expiry; every other command carries the time.
    assign in_time = (in_cmd.op == tts_pkg::OP_CREATE) ? create_time : now_t;

    // Queue control.
    assign s_axis_tready = (count_reg != CNT_W'(tts_pkg::QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign q_cmd         = cmd_mem[rd_ptr_reg];
    assign q_time        = time_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tts_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tts_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg]  <= in_cmd;
            time_mem[wr_ptr_reg] <= in_time;
        end
    end

endmodule

// File: design/tts_back.sv
// Back part of the timer table scheduler: slot table, scan sequencer and
// result register. Depends on tts_pkg.

module tts_back #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  tts_pkg::cmd_t           q_cmd,
    input  logic [TIME_BITS-1:0]    q_time,
    output logic                    q_pop,
    output logic                    res_valid,
    input  logic                    res_ready,
    output tts_pkg::result_t        res
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
    localparam logic [CW-1:0] SCAN_END = CW'(SLOTS);

    typedef struct packed {
        logic                 repeat_req;
        logic [TIME_BITS-1:0] expiry;
        logic [31:0]          interval;
        logic [15:0]          dest;
        logic [7:0]           msg_kind;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CREATE = 3'b010,
        ST_PROC   = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    tts_pkg::cmd_t          cur_reg, cur_next;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic                   ev_valid_reg, ev_valid_next;
    logic [SW-1:0]          ev_idx_reg, ev_idx_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [SLOTS-1:0]       used_reg, used_next;
    logic [SLOTS-1:0]       active_reg, active_next;
    logic                   out_valid_reg, out_valid_next;
    tts_pkg::result_t       out_reg, out_next;

    entry_t                 mem [SLOTS];
    entry_t                 rdata_reg;
    logic                   mem_we;
    logic [SW-1:0]          mem_waddr;
    entry_t                 mem_wdata;
    logic                   rd_en;
    logic [SW-1:0]          rd_addr;

    logic                   out_free;
    logic                   out_load;
    tts_pkg::result_t       out_new;
    logic [SW+3:0]          q_slot_ext;
    logic [SW-1:0]          q_idx;
    logic                   q_used;
    logic [SW-1:0]          scan_idx;
    logic [SW+3:0]          scan_idx_ext;
    logic [SW+3:0]          ev_idx_ext;
    logic [CW+4:0]          cnt_ext;
    logic                   ev_hit;
    logic [SUM_W-1:0]       resched_sum;
    logic [TIME_BITS-1:0]   resched_time;
    entry_t                 create_entry;

    // Output register frees when empty or when its transfer completes.
    assign out_free = !out_valid_reg || res_ready;

    // Addressed slot of the command at the head of the queue.
    assign q_slot_ext = {{SW{1'b0}}, q_cmd.slot};
    assign q_idx      = q_slot_ext[SW-1:0];
    assign q_used     = q_cmd.slot_ok && used_reg[q_idx];

    // Slot numbers and count reduced to their field widths.
    assign scan_idx     = scan_reg[SW-1:0];
    assign scan_idx_ext = {4'b0000, scan_idx};
    assign ev_idx_ext   = {4'b0000, ev_idx_reg};
    assign cnt_ext      = {5'b00000, cnt_reg};

    // Due check on the slot read in the previous step.
    assign ev_hit = used_reg[ev_idx_reg] && active_reg[ev_idx_reg]
                    && (time_reg >= rdata_reg.expiry);

    // Next expiry of a repeating slot, saturated.
    assign resched_sum  = SUM_W'(time_reg) + SUM_W'(rdata_reg.interval);
    assign resched_time = (|(resched_sum >> TIME_BITS)) ? {TIME_BITS{1'b1}}
                                                         : resched_sum[TIME_BITS-1:0];

    // Table entry written by a create.
    always_comb
    begin
        create_entry.repeat_req = cur_reg.repeat_req;
        create_entry.expiry     = time_reg;
        create_entry.interval   = cur_reg.interval;
        create_entry.dest       = cur_reg.dest;
        create_entry.msg_kind   = cur_reg.msg_kind;
    end

    // Command sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        time_next     = time_reg;
        scan_next     = scan_reg;
        ev_valid_next = ev_valid_reg;
        ev_idx_next   = ev_idx_reg;
        cnt_next      = cnt_reg;
        used_next     = used_reg;
        active_next   = active_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = ev_idx_reg;
        mem_wdata     = rdata_reg;
        rd_en         = 1'b0;
        rd_addr       = scan_idx;
        out_load      = 1'b0;
        out_new       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop     = 1'b1;
                    cur_next  = q_cmd;
                    time_next = q_time;
                    unique case (q_cmd.op)
                        tts_pkg::OP_CREATE:
                        begin
                            state_next = ST_CREATE;
                            scan_next  = '0;
                        end
                        tts_pkg::OP_PROCESS:
                        begin
                            state_next    = ST_PROC;
                            scan_next     = '0;
                            ev_valid_next = 1'b0;
                            cnt_next      = '0;
                        end
                        tts_pkg::OP_CANCEL, tts_pkg::OP_PAUSE,
                        tts_pkg::OP_RESUME, tts_pkg::OP_QUERY:
                        begin
                            out_load           = 1'b1;
                            out_new.kind       = tts_pkg::KIND_REPLY;
                            out_new.ok         = q_used;
                            out_new.slot_index = q_cmd.slot;
                            out_new.last       = 1'b1;
                            if (q_cmd.op == tts_pkg::OP_QUERY)
                            begin
                                out_new.is_active = q_used && active_reg[q_idx];
                            end
                            if (q_used && q_cmd.op == tts_pkg::OP_CANCEL)
                            begin
                                used_next[q_idx]   = 1'b0;
                                active_next[q_idx] = 1'b0;
                            end
                            if (q_used && q_cmd.op == tts_pkg::OP_PAUSE)
                            begin
                                active_next[q_idx] = 1'b0;
                            end
                            if (q_used && q_cmd.op == tts_pkg::OP_RESUME)
                            begin
                                active_next[q_idx] = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_load     = 1'b1;
                            out_new.kind = tts_pkg::KIND_REPLY;
                            out_new.last = 1'b1;
                        end
                    endcase
                end
            end

            // Search for the lowest free slot, one slot per cycle.
            ST_CREATE:
            begin
                if (scan_reg == SCAN_END)
                begin
                    if (out_free)
                    begin
                        out_load     = 1'b1;
                        out_new.kind = tts_pkg::KIND_REPLY;
                        out_new.last = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else if (!used_reg[scan_idx])
                begin
                    if (out_free)
                    begin
                        mem_we                = 1'b1;
                        mem_waddr             = scan_idx;
                        mem_wdata             = create_entry;
                        used_next[scan_idx]   = 1'b1;
                        active_next[scan_idx] = 1'b1;
                        out_load              = 1'b1;
                        out_new.kind          = tts_pkg::KIND_REPLY;
                        out_new.ok            = 1'b1;
                        out_new.slot_index    = scan_idx_ext[3:0];
                        out_new.last          = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // Process scan: read one slot, check it in the next cycle.
            ST_PROC:
            begin
                if (ev_valid_reg && out_free && ev_hit)
                begin
                    out_load           = 1'b1;
                    out_new.kind       = tts_pkg::KIND_FIRE;
                    out_new.ok         = 1'b1;
                    out_new.slot_index = ev_idx_ext[3:0];
                    out_new.fire_dest  = rdata_reg.dest;
                    out_new.fire_kind  = rdata_reg.msg_kind;
                    cnt_next           = cnt_reg + 1'b1;
                    if (rdata_reg.repeat_req)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata.expiry = resched_time;
                    end
                    else
                    begin
                        active_next[ev_idx_reg] = 1'b0;
                    end
                end

                if (!ev_valid_reg || out_free)
                begin
                    if (scan_reg != SCAN_END)
                    begin
                        rd_en         = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = scan_idx;
                        scan_next     = scan_reg + 1'b1;
                    end
                    else
                    begin
                        ev_valid_next = 1'b0;
                    end
                end

                if (!ev_valid_reg && scan_reg == SCAN_END && out_free)
                begin
                    out_load            = 1'b1;
                    out_new.kind        = tts_pkg::KIND_DONE;
                    out_new.ok          = 1'b1;
                    out_new.fired_count = cnt_ext[4:0];
                    out_new.last        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = out_new;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ev_valid_reg  <= 1'b0;
            used_reg      <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ev_valid_reg  <= ev_valid_next;
            used_reg      <= used_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        time_reg   <= time_next;
        scan_reg   <= scan_next;
        ev_idx_reg <= ev_idx_next;
        cnt_reg    <= cnt_next;
        out_reg    <= out_next;
    end

    // Slot table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

// File: sim/timer_table_scheduler_test.sv
// Self-checking testbench for the timer table scheduler: directed table, then random commands.
// Results are predicted by a local copy of the slot table and compared field by field.
// Depends on tts_pkg and the timer_table_scheduler RTL.
`timescale 1ns / 100ps

module timer_table_scheduler_test;

    localparam int          NUM_SLOTS    = 16;
    localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam int          RANDOM_ITEMS = 200;
    localparam int          CYCLE_LIMIT  = 3_000_000;
    localparam int          TAIL_CYCLES  = 2 * NUM_SLOTS + 8;

    // Command codes that the block does not define.
    localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
    localparam logic [2:0] CMD_UNDEF_7 = 3'd7;

    // One command as it travels on the input stream.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  slot;
        logic [15:0] dest;
        logic [7:0]  mkind;
        logic [31:0] interval;
        logic [31:0] delay;
        logic        rep;
        logic [47:0] now;
    } timer_cmd_t;

    // One row of the directed table; exp_r holds a typed-in result when has_exp is set.
    typedef struct {
        timer_cmd_t       c;
        bit               has_exp;
        tts_pkg::result_t exp_r;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tts_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [tts_pkg::IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [tts_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [tts_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    logic                            m_axis_tlast;

    // Local copy of the slot table.
    logic        tm_used     [NUM_SLOTS];
    logic        tm_active   [NUM_SLOTS];
    logic        tm_repeat   [NUM_SLOTS];
    logic [47:0] tm_expiry   [NUM_SLOTS];
    logic [31:0] tm_interval [NUM_SLOTS];
    logic [15:0] tm_dest     [NUM_SLOTS];
    logic [7:0]  tm_kind     [NUM_SLOTS];

    tts_pkg::result_t pending_results [$];
    tts_pkg::result_t fresh_results   [$];
    stim_row_t        directed_rows   [$];

    int          err_count      = 0;
    int          cycle_count    = 0;
    int          items_sent     = 0;
    int          results_seen   = 0;
    int          fires_expected = 0;
    int          full_rejects   = 0;
    bit          quiet_phase    = 1'b0;
    logic [47:0] clock_now      = '0;
    int          rx_hold        = 0;
    logic        rx_ready_next  = 1'b1;

    timer_table_scheduler #(
        .SLOTS     (NUM_SLOTS),
        .TIME_BITS (48)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic tts_pkg::result_t make_result(input tts_pkg::res_kind_t kind,
                                                     input logic ok,
                                                     input logic [3:0] idx,
                                                     input logic [4:0] cnt);
        tts_pkg::result_t r;
        r = '0;
        r.kind        = kind;
        r.ok          = ok;
        r.slot_index  = idx;
        r.fired_count = cnt;
        r.last        = 1'b1;
        return r;
    endfunction

    // Expiry sum, saturating at the largest 48-bit time.
    function automatic logic [47:0] saturate_expiry(input logic [47:0] base,
                                                    input logic [31:0] offset);
        logic [48:0] total;
        total = {1'b0, base} + {17'b0, offset};
        return total[48] ? TIME_MAX : total[47:0];
    endfunction

    // Applies one command to the local table and leaves its results in fresh_results.
    task automatic predict_timer(input timer_cmd_t c);
        logic             used;
        logic             placed;
        int               fired;
        tts_pkg::result_t r;
        fresh_results.delete();
        used   = tm_used[c.slot];
        placed = 1'b0;
        r      = make_result(tts_pkg::KIND_REPLY, 1'b0, 4'd0, 5'd0);
        case (c.cmd)
            tts_pkg::CMD_CREATE:
            begin
                if (c.interval != 0)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!placed && !tm_used[i])
                        begin
                            placed         = 1'b1;
                            tm_used[i]     = 1'b1;
                            tm_active[i]   = 1'b1;
                            tm_repeat[i]   = c.rep;
                            tm_interval[i] = c.interval;
                            tm_dest[i]     = c.dest;
                            tm_kind[i]     = c.mkind;
                            tm_expiry[i]   = saturate_expiry(c.now, c.delay);
                            r.ok           = 1'b1;
                            r.slot_index   = i[3:0];
                        end
                    end
                    if (!placed)
                        full_rejects++;
                end
                fresh_results.push_back(r);
            end
            tts_pkg::CMD_CANCEL:
            begin
                if (used)
                begin
                    tm_used[c.slot]   = 1'b0;
                    tm_active[c.slot] = 1'b0;
                end
                r.ok         = used;
                r.slot_index = c.slot;
                fresh_results.push_back(r);
            end
            tts_pkg::CMD_PAUSE, tts_pkg::CMD_RESUME:
            begin
                if (used)
                    tm_active[c.slot] = (c.cmd == tts_pkg::CMD_RESUME);
                r.ok         = used;
                r.slot_index = c.slot;
                fresh_results.push_back(r);
            end
            tts_pkg::CMD_PROCESS:
            begin
                // Scan in index order; each due slot fires, then repeats or goes inactive.
                fired = 0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (tm_used[i] && tm_active[i] && c.now >= tm_expiry[i])
                    begin
                        r            = '0;
                        r.kind       = tts_pkg::KIND_FIRE;
                        r.ok         = 1'b1;
                        r.slot_index = i[3:0];
                        r.fire_dest  = tm_dest[i];
                        r.fire_kind  = tm_kind[i];
                        fresh_results.push_back(r);
                        fired++;
                        if (tm_repeat[i])
                            tm_expiry[i] = saturate_expiry(c.now, tm_interval[i]);
                        else
                            tm_active[i] = 1'b0;
                    end
                end
                fires_expected += fired;
                fresh_results.push_back(make_result(tts_pkg::KIND_DONE, 1'b1, 4'd0,
                                                    fired[4:0]));
            end
            tts_pkg::CMD_QUERY:
            begin
                r.ok         = used;
                r.slot_index = c.slot;
                r.is_active  = used && tm_active[c.slot];
                fresh_results.push_back(r);
            end
            default:
            begin
                fresh_results.push_back(r);
            end
        endcase
    endtask

    // Sender gap or receiver stall length: mostly short, a few long.
    function automatic int stall_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Drives one command, waits for its transfer, then records what it must produce.
    task automatic send_item(input timer_cmd_t c, input bit has_exp,
                             input tts_pkg::result_t exp_r);
        int gap;
        gap = (quiet_phase || $urandom_range(0, 99) < 45) ? 0 : stall_len();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, c.now, c.rep, c.delay, c.interval, c.mkind, c.dest, c.slot};
        s_axis_tuser  <= c.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_timer(c);
        if (has_exp)
            pending_results.push_back(exp_r);
        else
            foreach (fresh_results[i])
                pending_results.push_back(fresh_results[i]);
        items_sent++;
    endtask

    // Holds the sender off until every expected result has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [2:0] cmd, input logic [3:0] slot,
                           input logic [15:0] dest, input logic [7:0] mkind,
                           input logic [31:0] interval, input logic [31:0] delay,
                           input logic rep, input logic [47:0] now,
                           input bit has_exp, input tts_pkg::result_t exp_r);
        stim_row_t row;
        row.c       = '{cmd, slot, dest, mkind, interval, delay, rep, now};
        row.has_exp = has_exp;
        row.exp_r   = exp_r;
        directed_rows.push_back(row);
    endtask

    function automatic logic [3:0] pick_slot();
        int used_list [$];
        for (int i = 0; i < NUM_SLOTS; i++)
            if (tm_used[i])
                used_list.push_back(i);
        if (used_list.size() != 0 && $urandom_range(0, 99) < 75)
            return 4'(used_list[$urandom_range(0, used_list.size() - 1)]);
        return 4'($urandom_range(0, NUM_SLOTS - 1));
    endfunction

    // Every field random; scenarios then overwrite the fields that matter.
    function automatic timer_cmd_t rand_item();
        timer_cmd_t c;
        c.cmd      = 3'($urandom_range(0, 7));
        c.slot     = 4'($urandom_range(0, 15));
        c.dest     = 16'($urandom_range(0, 65535));
        c.mkind    = 8'($urandom_range(0, 255));
        c.interval = $urandom;
        c.delay    = $urandom;
        c.rep      = 1'($urandom_range(0, 1));
        c.now      = {16'($urandom_range(0, 65535)), 32'($urandom)};
        return c;
    endfunction

    function automatic timer_cmd_t make_create();
        timer_cmd_t c;
        int         pick;
        c     = rand_item();
        c.cmd = tts_pkg::CMD_CREATE;
        pick  = $urandom_range(0, 99);
        if (pick < 80)
            c.interval = $urandom_range(1, 60);
        else if (pick < 87)
            c.interval = '0;
        else if (pick < 92)
            c.interval = 32'hFFFF_FFFF;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            c.delay = $urandom_range(0, 60);
        else if (pick < 85)
            c.delay = '0;
        if ($urandom_range(0, 9) != 0)
            c.now = clock_now;
        return c;
    endfunction

    function automatic timer_cmd_t make_process();
        timer_cmd_t c;
        c     = rand_item();
        c.cmd = tts_pkg::CMD_PROCESS;
        if ($urandom_range(0, 99) < 4)
            clock_now = TIME_MAX - 48'($urandom_range(0, 200));
        else
            clock_now = clock_now + 48'($urandom_range(0, 40));
        if ($urandom_range(0, 19) != 0)
            c.now = clock_now;
        return c;
    endfunction

    // Checks one result transfer against the oldest expectation.
    task automatic check_field(input int n, input string name,
                               input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                      n, name, got, want));
    endtask

    task automatic check_result();
        tts_pkg::result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
        end
        want = pending_results.pop_front();
        check_field(results_seen, "kind",        64'(m_axis_tuser[1:0]),   64'(want.kind));
        check_field(results_seen, "ok",          64'(m_axis_tdata[0]),     64'(want.ok));
        check_field(results_seen, "slot_index",  64'(m_axis_tdata[4:1]),   64'(want.slot_index));
        check_field(results_seen, "fire_dest",   64'(m_axis_tdata[20:5]),  64'(want.fire_dest));
        check_field(results_seen, "fire_kind",   64'(m_axis_tdata[28:21]), 64'(want.fire_kind));
        check_field(results_seen, "fired_count", 64'(m_axis_tdata[33:29]),
                    64'(want.fired_count));
        check_field(results_seen, "is_active",   64'(m_axis_tdata[34]),    64'(want.is_active));
        check_field(results_seen, "tlast",       64'(m_axis_tlast),        64'(want.last));
    endtask

    // Result side: check each transfer, then choose ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
        if (rx_hold == 0)
        begin
            if (quiet_phase || $urandom_range(0, 99) < 60)
            begin
                rx_ready_next = 1'b1;
                rx_hold       = $urandom_range(1, 20);
            end
            else
            begin
                rx_ready_next = 1'b0;
                rx_hold       = stall_len();
            end
        end
        else
        begin
            rx_hold--;
        end
        m_axis_tready <= rx_ready_next;
    end

    // Stimulus sequence.
    initial
    begin
        timer_cmd_t       c;
        int               pick;
        tts_pkg::result_t none;
        none = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tm_used[i]   = 1'b0;
            tm_active[i] = 1'b0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty table, rejects, extremes, saturation, overdue resume.
        add_row(tts_pkg::CMD_QUERY,   4'd0,  16'h0,    8'h0,  32'h0,  32'h0,  1'b0, 48'h0, 1,
                make_result(tts_pkg::KIND_REPLY, 1'b0, 4'd0, 5'd0));
        add_row(tts_pkg::CMD_PROCESS, 4'd0,  16'h0,    8'h0,  32'h0,  32'h0,  1'b0, 48'h0, 1,
                make_result(tts_pkg::KIND_DONE, 1'b1, 4'd0, 5'd0));
        add_row(tts_pkg::CMD_CREATE,  4'd9,  16'hABCD, 8'h33, 32'h0,  32'h5,  1'b1, 48'h10, 1,
                make_result(tts_pkg::KIND_REPLY, 1'b0, 4'd0, 5'd0));
        add_row(CMD_UNDEF_6, 4'd5,  16'h1111, 8'h11, 32'h1,  32'h1,  1'b1, 48'h1, 1,
                make_result(tts_pkg::KIND_REPLY, 1'b0, 4'd0, 5'd0));
        add_row(CMD_UNDEF_7, 4'd15, 16'h2222, 8'h22, 32'h2,  32'h2,  1'b0, 48'h2, 1,
                make_result(tts_pkg::KIND_REPLY, 1'b0, 4'd0, 5'd0));
        add_row(tts_pkg::CMD_CANCEL,  4'd15, 16'h0,    8'h0,  32'h0,  32'h0,  1'b0, 48'h0, 1,
                make_result(tts_pkg::KIND_REPLY, 1'b0, 4'd15, 5'd0));
        add_row(tts_pkg::CMD_PAUSE,   4'd3,  16'h0,    8'h0,  32'h0,  32'h0,  1'b0, 48'h0, 1,
                make_result(tts_pkg::KIND_REPLY, 1'b0, 4'd3, 5'd0));
        add_row(tts_pkg::CMD_RESUME,  4'd3,  16'h0,    8'h0,  32'h0,  32'h0,  1'b0, 48'h0, 1,
                make_result(tts_pkg::KIND_REPLY, 1'b0, 4'd3, 5'd0));
        add_row(tts_pkg::CMD_CREATE,  4'd0,  16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'h0, 1'b1,
                48'h0, 1, make_result(tts_pkg::KIND_REPLY, 1'b1, 4'd0, 5'd0));
        add_row(tts_pkg::CMD_CREATE,  4'd0,  16'h0,    8'h0,  32'h1,  32'hFFFF_FFFF, 1'b0,
                TIME_MAX, 1, make_result(tts_pkg::KIND_REPLY, 1'b1, 4'd1, 5'd0));
        add_row(tts_pkg::CMD_CREATE,  4'd7,  16'h1234, 8'h5A, 32'd16, 32'd5,  1'b1, 48'd100, 1,
                make_result(tts_pkg::KIND_REPLY, 1'b1, 4'd2, 5'd0));
        add_row(tts_pkg::CMD_PROCESS, 4'd0,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 48'h0,   0, none);
        add_row(tts_pkg::CMD_QUERY,   4'd0,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 48'h0,   0, none);
        add_row(tts_pkg::CMD_PROCESS, 4'd0,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 48'd104, 0, none);
        add_row(tts_pkg::CMD_PROCESS, 4'd0,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 48'd105, 0, none);
        add_row(tts_pkg::CMD_PROCESS, 4'd0,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, TIME_MAX, 0, none);
        add_row(tts_pkg::CMD_QUERY,   4'd1,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 48'h0,   0, none);
        add_row(tts_pkg::CMD_RESUME,  4'd1,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 48'h0,   0, none);
        add_row(tts_pkg::CMD_PROCESS, 4'd0,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, TIME_MAX, 0, none);
        add_row(tts_pkg::CMD_PAUSE,   4'd0,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 48'h0,   0, none);
        add_row(tts_pkg::CMD_PROCESS, 4'd0,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, TIME_MAX, 0, none);
        add_row(tts_pkg::CMD_CANCEL,  4'd2,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 48'h0,   0, none);
        add_row(tts_pkg::CMD_QUERY,   4'd2,  16'h0, 8'h0, 32'h0, 32'h0, 1'b0, 48'h0,   0, none);
        add_row(tts_pkg::CMD_CREATE,  4'd0,  16'h0, 8'h0, 32'd7, 32'h0, 1'b0, 48'd50,  0, none);
        foreach (directed_rows[i])
            send_item(directed_rows[i].c, directed_rows[i].has_exp, directed_rows[i].exp_r);

        // Random part: mostly well-formed commands on live slots, with some noise.
        wait_drained();
        clock_now = 48'd1000;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_phase = (n >= 160 && n < 190);
            if (n == 100)
                wait_drained();
            // Fill the table to the top and one past it.
            if (n == 50 || n == 140)
            begin
                repeat (NUM_SLOTS + 1)
                begin
                    c          = make_create();
                    c.interval = $urandom_range(1, 50);
                    send_item(c, 0, none);
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                c = make_create();
            end
            else if (pick < 55)
            begin
                c = make_process();
            end
            else if (pick < 94)
            begin
                c      = rand_item();
                c.slot = pick_slot();
                if (pick < 63)
                    c.cmd = tts_pkg::CMD_PAUSE;
                else if (pick < 71)
                    c.cmd = tts_pkg::CMD_RESUME;
                else if (pick < 80)
                    c.cmd = tts_pkg::CMD_CANCEL;
                else
                    c.cmd = tts_pkg::CMD_QUERY;
            end
            else if (pick < 97)
            begin
                c     = rand_item();
                c.cmd = $urandom_range(0, 1) ? CMD_UNDEF_6 : CMD_UNDEF_7;
            end
            else
            begin
                c = rand_item();
            end
            send_item(c, 0, none);
        end
        quiet_phase = 1'b0;

        // Let the last results out, then allow for any late extra transfer.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands and %0d results, with %0d timer firings expected,",
                 items_sent, results_seen, fires_expected);
        $display("%0d creates refused on a full table, and saturated expiry times.",
                 full_rejects);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
